// ===== sv/assert_macros.svh =====
// Assertion helper macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== sv/wwrb_pkg.sv =====
// ----------------------------------------------------------------------------
// wwrb_pkg
// Shared types and codes of the word wrap row break block.
// ----------------------------------------------------------------------------
`default_nettype none
package wwrb_pkg;

	localparam logic [1:0] KIND_GLYPH = 2'd0;
	localparam logic [1:0] KIND_SPACE = 2'd1;
	localparam logic [1:0] KIND_TAB   = 2'd2;
	localparam logic [1:0] KIND_EOL   = 2'd3;

	localparam int unsigned WRAP_W   = 10;
	localparam int unsigned TAB_W    = 6;
	localparam int unsigned COL_OUT_W = 16;

	localparam logic [WRAP_W-1:0] WRAP_RST = 10'd79;
	localparam logic [TAB_W-1:0]  TAB_RST  = 6'd8;

	typedef struct packed {
		logic [1:0] wd;
		logic [1:0] kind;
	} entry_t;

endpackage
`default_nettype wire

// ===== sv/wwrb_fifo.sv =====
// ----------------------------------------------------------------------------
// wwrb_fifo
// Two-entry queue of line descriptors between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module wwrb_fifo #(
	parameter int unsigned W = 12
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	input  wire logic         pop,
	output logic [W-1:0]      pop_data,
	output logic              full,
	output logic              empty
);
	logic [W-1:0] data_q [2];
	logic         wptr_q;
	logic         rptr_q;
	logic [1:0]   cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign pop_data = data_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

// ===== sv/wwrb_front.sv =====
// ----------------------------------------------------------------------------
// wwrb_front
// Accepts character beats, classifies them into the line store, and queues
// a descriptor at end of line. Holds off input until the back frees the store.
// ----------------------------------------------------------------------------
`default_nettype none
module wwrb_front import wwrb_pkg::*; #(
	parameter int unsigned MAX_CHARS = 1024,
	parameter int unsigned CW = $clog2(MAX_CHARS + 1),
	parameter int unsigned AW = $clog2(MAX_CHARS)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [1:0]    kind,
	input  wire logic [1:0]    glyph_width,
	output logic               q_push,
	output logic [CW:0]        q_data,
	input  wire logic          q_full,
	input  wire logic          store_free,
	input  wire logic [AW-1:0] rd_addr,
	output entry_t             rd_data
);
	entry_t        mem [MAX_CHARS];
	entry_t        rd_q;
	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic          busy_q;
	logic          acc;
	logic          room;
	entry_t        ent;

	assign in_ready = !busy_q && !q_full;
	assign acc      = in_valid && in_ready;
	assign room     = (cnt_q < CW'(MAX_CHARS));
	assign q_push   = acc && (kind == KIND_EOL);
	assign q_data   = {ovf_q, cnt_q};
	assign rd_data  = rd_q;

	always_comb begin
		ent.kind = kind;
		if (kind != KIND_GLYPH) begin
			ent.wd = 2'd0;
		end else if (glyph_width == 2'd3) begin
			ent.wd = 2'd2;
		end else begin
			ent.wd = glyph_width;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && (kind != KIND_EOL) && room) begin
			mem[cnt_q[AW-1:0]] <= ent;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
			busy_q <= 1'b0;
		end else begin
			if (store_free) begin
				busy_q <= 1'b0;
			end
			if (acc) begin
				if (kind == KIND_EOL) begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
					ovf_q  <= 1'b0;
				end else if (room) begin
					cnt_q <= cnt_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== sv/wwrb_back.sv =====
// ----------------------------------------------------------------------------
// wwrb_back
// Greedy wrap sequencer: walks the stored line, records row starts in a row
// memory, then plays the rows out on the result channel.
// ----------------------------------------------------------------------------
`default_nettype none
module wwrb_back import wwrb_pkg::*; #(
	parameter int unsigned MAX_CHARS = 1024,
	parameter int unsigned MAX_ROWS  = 64,
	parameter int unsigned CW  = $clog2(MAX_CHARS + 1),
	parameter int unsigned AW  = $clog2(MAX_CHARS),
	parameter int unsigned RW  = $clog2(MAX_ROWS + 1),
	parameter int unsigned RAW = $clog2(MAX_ROWS),
	parameter int unsigned VXW = $clog2(MAX_CHARS * 64) + 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [WRAP_W-1:0] wrap_width,
	input  wire logic [TAB_W-1:0]  tab_stop,
	input  wire logic              q_empty,
	input  wire logic [CW:0]       q_data,
	output logic                   q_pop,
	output logic                   store_free,
	output logic [AW-1:0]          rd_addr,
	input  entry_t                 rd_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [5:0]             row_index,
	output logic [COL_OUT_W-1:0]   row_start_column,
	output logic                   last_row,
	output logic                   chars_dropped,
	output logic                   rows_capped
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_INIT = 4'd1;
	localparam logic [3:0] S_RD   = 4'd2;
	localparam logic [3:0] S_EV   = 4'd3;
	localparam logic [3:0] S_WRD  = 4'd4;
	localparam logic [3:0] S_WEV  = 4'd5;
	localparam logic [3:0] S_WDEC = 4'd6;
	localparam logic [3:0] S_PRD  = 4'd7;
	localparam logic [3:0] S_PEV  = 4'd8;
	localparam logic [3:0] S_FREE = 4'd9;
	localparam logic [3:0] S_ORD  = 4'd10;
	localparam logic [3:0] S_OLD  = 4'd11;
	localparam logic [3:0] S_OUT  = 4'd12;

	logic [3:0]           state_q;
	logic [CW-1:0]        cnt_q;
	logic                 ovf_q;
	logic [CW-1:0]        i_q;
	logic [CW-1:0]        j_q;
	logic [VXW-1:0]       vx_q;
	logic [VXW-1:0]       rb_q;
	logic [VXW-1:0]       ww_q;
	logic [TAB_W-1:0]     rem_q;
	logic [RW-1:0]        rows_q;
	logic                 over_q;
	logic [RW-1:0]        orow_q;
	logic [COL_OUT_W-1:0] rowmem [MAX_ROWS];
	logic [COL_OUT_W-1:0] row_rd_q;

	logic [VXW-1:0]   w_eff;
	logic [TAB_W-1:0] t_eff;
	logic [VXW-1:0]   used;
	logic [VXW-1:0]   cw;
	logic [VXW:0]     span;
	logic             br_en;
	logic [VXW-1:0]   br_col;
	logic             adv_en;
	logic             adv_tab;
	logic [TAB_W:0]   rem_sum;
	logic [TAB_W-1:0] rem_nxt;
	logic             row_room;

	assign w_eff    = (wrap_width == '0) ? VXW'(1) : VXW'(wrap_width);
	assign t_eff    = (tab_stop == '0) ? TAB_W'(1) : tab_stop;
	assign used     = vx_q - rb_q;
	assign row_room = (rows_q < RW'(MAX_ROWS));
	assign rem_sum  = {1'b0, rem_q} + (TAB_W + 1)'(cw);

	always_comb begin
		if (adv_tab || (t_eff == TAB_W'(1))) begin
			rem_nxt = '0;
		end else if (rem_sum >= {1'b0, t_eff}) begin
			rem_nxt = TAB_W'(rem_sum - {1'b0, t_eff});
		end else begin
			rem_nxt = rem_sum[TAB_W-1:0];
		end
	end

	always_comb begin
		cw      = '0;
		adv_tab = 1'b0;
		if (rd_data.kind == KIND_TAB) begin
			cw      = VXW'(t_eff - rem_q);
			adv_tab = (state_q == S_EV);
		end else if (rd_data.kind == KIND_GLYPH) begin
			cw = VXW'(rd_data.wd);
		end else begin
			cw = VXW'(1);
		end
		span     = {1'b0, used} + {1'b0, cw};
		br_en    = 1'b0;
		br_col   = vx_q;
		adv_en   = 1'b0;
		rd_addr  = i_q[AW-1:0];
		q_pop    = 1'b0;
		store_free = 1'b0;
		case (state_q)
			S_IDLE: begin
				q_pop = !q_empty;
			end
			S_EV: begin
				if (rd_data.kind != KIND_GLYPH) begin
					adv_en = 1'b1;
					if (span > {1'b0, w_eff}) begin
						br_en  = 1'b1;
						br_col = vx_q + cw;
					end
				end
			end
			S_WRD: begin
				rd_addr = j_q[AW-1:0];
			end
			S_WDEC: begin
				br_en = (vx_q > rb_q) && (({1'b0, used} + {1'b0, ww_q}) > {1'b0, w_eff})
					&& (ww_q <= w_eff);
			end
			S_PEV: begin
				adv_en = 1'b1;
				br_en  = (cw != '0) && (span > {1'b0, w_eff});
			end
			S_FREE: begin
				store_free = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_INIT) begin
			rowmem[0] <= '0;
		end else if (br_en && row_room) begin
			rowmem[rows_q[RAW-1:0]] <= br_col[COL_OUT_W-1:0];
		end
		row_rd_q <= rowmem[orow_q[RAW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			vx_q      <= '0;
			rb_q      <= '0;
			ww_q      <= '0;
			rem_q     <= '0;
			rows_q    <= '0;
			over_q    <= 1'b0;
			orow_q    <= '0;
			out_valid <= 1'b0;
			row_index        <= '0;
			row_start_column <= '0;
			last_row         <= 1'b0;
			chars_dropped    <= 1'b0;
			rows_capped      <= 1'b0;
		end else begin
			if (br_en) begin
				rb_q <= br_col;
				if (row_room) begin
					rows_q <= rows_q + RW'(1);
				end else begin
					over_q <= 1'b1;
				end
			end
			if (adv_en) begin
				vx_q  <= vx_q + cw;
				rem_q <= rem_nxt;
				i_q   <= i_q + CW'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						cnt_q   <= q_data[CW-1:0];
						ovf_q   <= q_data[CW];
						state_q <= S_INIT;
					end
				end
				S_INIT: begin
					i_q     <= '0;
					vx_q    <= '0;
					rb_q    <= '0;
					rem_q   <= '0;
					rows_q  <= RW'(1);
					over_q  <= 1'b0;
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= (i_q >= cnt_q) ? S_FREE : S_EV;
				end
				S_EV: begin
					if (rd_data.kind != KIND_GLYPH) begin
						state_q <= S_RD;
					end else begin
						j_q     <= i_q;
						ww_q    <= '0;
						state_q <= S_WRD;
					end
				end
				S_WRD: begin
					state_q <= (j_q >= cnt_q) ? S_WDEC : S_WEV;
				end
				S_WEV: begin
					if (rd_data.kind == KIND_GLYPH) begin
						ww_q    <= ww_q + VXW'(rd_data.wd);
						j_q     <= j_q + CW'(1);
						state_q <= S_WRD;
					end else begin
						state_q <= S_WDEC;
					end
				end
				S_WDEC: begin
					state_q <= S_PRD;
				end
				S_PRD: begin
					state_q <= (i_q >= j_q) ? S_RD : S_PEV;
				end
				S_PEV: begin
					state_q <= S_PRD;
				end
				S_FREE: begin
					orow_q  <= '0;
					state_q <= S_ORD;
				end
				S_ORD: begin
					state_q <= S_OLD;
				end
				S_OLD: begin
					row_index        <= 6'(orow_q);
					row_start_column <= row_rd_q;
					last_row         <= (orow_q + RW'(1) == rows_q);
					chars_dropped    <= ovf_q;
					rows_capped      <= over_q;
					out_valid        <= 1'b1;
					state_q          <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						if (orow_q + RW'(1) == rows_q) begin
							state_q <= S_IDLE;
						end else begin
							orow_q  <= orow_q + RW'(1);
							state_q <= S_ORD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== sv/word_wrap_row_breaks.sv =====
// ----------------------------------------------------------------------------
// word_wrap_row_breaks
// Greedy word wrap of one text line into screen row start columns.
// ----------------------------------------------------------------------------
// Input beats carry one character each (glyph, space, tab) or end of line.
// Characters are stored at one per cycle while in_ready is high. End of
// line queues the line for the wrap sequencer and input is held off until
// the sequencer has walked the store; the next line then loads while row
// starts are played out. Wrapping reads each space or tab once; each glyph
// word is read twice, once to size it and once to place it, with a break
// decision between the two passes. Output: one beat per row, row_index
// counting from 0 and last_row on the final beat. A stalled sink freezes
// the sequencer on the current beat; loading of the next line goes on.
// Reset clears all control state; wrap_width returns to 79, tab_stop to 8.
// The line store needs no clearing pass.
// Config: wrap_width at 0x0, tab_stop at 0x4; write only while idle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module word_wrap_row_breaks import wwrb_pkg::*; #(
	parameter int unsigned MAX_CHARS = 1024,
	parameter int unsigned MAX_ROWS  = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  kind,
	input  wire logic [1:0]  glyph_width,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [5:0]       row_index,
	output logic [15:0]      row_start_column,
	output logic             last_row,
	output logic             chars_dropped,
	output logic             rows_capped
);
	localparam int unsigned CW = $clog2(MAX_CHARS + 1);
	localparam int unsigned AW = $clog2(MAX_CHARS);

	logic [WRAP_W-1:0] wrap_q;
	logic [TAB_W-1:0]  tab_q;
	logic              q_push;
	logic              q_pop;
	logic              q_full;
	logic              q_empty;
	logic [CW:0]       q_wdata;
	logic [CW:0]       q_rdata;
	logic              store_free;
	logic [AW-1:0]     rd_addr;
	entry_t            rd_data;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? {26'd0, tab_q} : {22'd0, wrap_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_q <= WRAP_RST;
			tab_q  <= TAB_RST;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2]) begin
				tab_q <= pwdata[TAB_W-1:0];
			end else begin
				wrap_q <= pwdata[WRAP_W-1:0];
			end
		end
	end

	wwrb_front #(.MAX_CHARS(MAX_CHARS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .glyph_width(glyph_width),
		.q_push(q_push), .q_data(q_wdata), .q_full(q_full),
		.store_free(store_free), .rd_addr(rd_addr), .rd_data(rd_data)
	);

	wwrb_fifo #(.W(CW + 1)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .push_data(q_wdata),
		.pop(q_pop), .pop_data(q_rdata),
		.full(q_full), .empty(q_empty)
	);

	wwrb_back #(.MAX_CHARS(MAX_CHARS), .MAX_ROWS(MAX_ROWS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.wrap_width(wrap_q), .tab_stop(tab_q),
		.q_empty(q_empty), .q_data(q_rdata), .q_pop(q_pop),
		.store_free(store_free), .rd_addr(rd_addr), .rd_data(rd_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.row_index(row_index), .row_start_column(row_start_column),
		.last_row(last_row), .chars_dropped(chars_dropped),
		.rows_capped(rows_capped)
	);

	`ASSERT_NOW(a_no_q_overflow, clk, arst_n, q_push, !q_full)
	`ASSERT_NOW(a_row0_col0, clk, arst_n, out_valid && (row_index == 6'd0),
		row_start_column == 16'd0)
	`ASSERT_NOW(a_desc_count, clk, arst_n, q_push, q_wdata[CW-1:0] <= CW'(MAX_CHARS))
	`ASSERT_NEXT(a_free_opens, clk, arst_n, store_free && !q_full, in_ready)

endmodule
`default_nettype wire
